// File: hdl/mws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_pkg
// Shared types and fixed widths for the maximum window sum block.
// ----------------------------------------------------------------------------
package mws_pkg;

  localparam int VALUE_W = 32;  // input sample width
  localparam int SUM_W   = 40;  // reported sum width
  localparam int START_W = 10;  // reported start index width
  localparam int CFG_W   = 9;   // window length config write width

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } mws_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] best_sum;
    logic [START_W-1:0]      best_start;
    logic                    window_full;
    logic                    set_done;
  } mws_out_t;

endpackage

// File: hdl/mws_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_cell
// One stage of the sample delay line: takes its upstream neighbor's sample
// on every shift.
// ----------------------------------------------------------------------------
module mws_cell
  import mws_pkg::*;
(
  input  logic                      clk,
  input  logic                      shift,
  input  logic signed [VALUE_W-1:0] prev,
  output logic signed [VALUE_W-1:0] data
);

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= prev;
    end
  end

endmodule

// File: hdl/mws_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_window
// Row of sample cells ordered by age, newest in the first cell. A registered
// read hands back the sample that leaves the window at the next shift.
// ----------------------------------------------------------------------------
module mws_window
  import mws_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int POS_W = 8,
  parameter int LEN_W = 9
) (
  input  logic                      clk,
  input  logic                      shift,
  input  logic [LEN_W-1:0]          rd_len,
  input  logic signed [VALUE_W-1:0] din,
  output logic signed [VALUE_W-1:0] dout
);

  logic signed [VALUE_W-1:0] tap [DEPTH];
  logic [LEN_W-1:0]          rd_age;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] prev;
    if (i == 0) begin : g_head
      assign prev = din;
    end else begin : g_body
      assign prev = tap[i-1];
    end
    mws_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .prev  (prev),
      .data  (tap[i])
    );
  end

  // age of the next leaving sample, seen from the cells before this edge
  assign rd_age = shift ? (rd_len - LEN_W'(2)) : (rd_len - LEN_W'(1));

  always_ff @(posedge clk) begin
    if (shift && rd_len == LEN_W'(1)) begin
      dout <= din;
    end else begin
      dout <= tap[POS_W'(rd_age)];
    end
  end

endmodule

// File: hdl/max_window_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_window_sum
// Streaming maximum sum over a sliding window of window_len samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one signed sample per request, last marks the end of a data set.
//   out_*  : one result per input request: best window sum and its start
//            index so far in the set, window_full, and set_done for last.
//   cfg_*  : writes window_len (0 acts as 1, above MAX_WINDOW clamps). Always
//            ready; write it between sets.
// One request per cycle while in_ready is high; each result is registered in
// the output register, or the skid entry if the head stalls. The pace is set
// by the running-sum update (one add, one subtract, one compare per sample)
// and the MAX_WINDOW-cell delay line that hands back the leaving sample.
// A two-entry output buffer lets the block take a new request while a result
// waits; in_ready drops only once both entries are held by a stalled
// receiver. Reset empties the buffer, clears the set state and sets the
// window length to 1. The delay line needs no clearing. Samples past
// MAX_ITEMS in one set are ignored; results then repeat the current best.
// ----------------------------------------------------------------------------
module max_window_sum
  import mws_pkg::*;
#(
  parameter int MAX_WINDOW = 256,
  parameter int MAX_ITEMS  = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mws_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output mws_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int POS_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int GROW_W = VALUE_W + 1 + $clog2(MAX_WINDOW);
  localparam int ACC_W = (GROW_W > SUM_W) ? GROW_W : SUM_W;

  // configuration
  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] rd_len;
  logic [LEN_W-1:0] cfg_eff;

  // set state
  logic signed [ACC_W-1:0] running_sum;
  logic signed [ACC_W-1:0] best;
  logic [IDX_W-1:0]        best_index;
  logic                    best_valid;
  logic [CNT_W-1:0]        count;

  // datapath
  logic                      accept;
  logic                      active;
  logic                      shift;
  logic signed [VALUE_W-1:0] leaving;
  logic [CMP_W-1:0]          cnt_x;
  logic [CMP_W-1:0]          len_x;
  logic [CMP_W-1:0]          cnt_new_x;
  logic [CMP_W-1:0]          start_x;
  logic signed [ACC_W-1:0]   sub;
  logic signed [ACC_W-1:0]   sum_new;
  logic                      full_now;
  logic                      take;
  logic                      res_bv;
  logic signed [ACC_W-1:0]   res_sum;
  logic [IDX_W-1:0]          res_idx;
  logic [IDX_W+START_W-1:0]  res_idx_ext;
  mws_out_t                  res;

  // output buffer
  mws_out_t skid;
  logic     skid_valid;
  logic     pop;
  logic     out_valid_next;
  logic     skid_valid_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_eff = LEN_W'(1);
    end else if (32'(cfg_data) > MAX_WINDOW) begin
      cfg_eff = LEN_W'(MAX_WINDOW);
    end else begin
      cfg_eff = LEN_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_len <= LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      eff_len <= cfg_eff;
    end
  end

  // length seen by the next sample, so the leaving-sample read follows a write
  assign rd_len = (cfg_valid && cfg_ready) ? cfg_eff : eff_len;

  assign accept = in_valid && in_ready;
  assign active = count < CNT_W'(MAX_ITEMS);
  assign shift  = accept && active;

  mws_window #(
    .DEPTH (MAX_WINDOW),
    .POS_W (POS_W),
    .LEN_W (LEN_W)
  ) u_window (
    .clk    (clk),
    .shift  (shift),
    .rd_len (rd_len),
    .din    (in_data.value),
    .dout   (leaving)
  );

  always_comb begin
    cnt_x     = CMP_W'(count);
    len_x     = CMP_W'(eff_len);
    cnt_new_x = cnt_x + CMP_W'(1);
    start_x   = cnt_new_x - len_x;
    sub       = (cnt_x >= len_x) ? ACC_W'(leaving) : '0;
    sum_new   = running_sum + ACC_W'(in_data.value) - sub;
    full_now  = cnt_new_x >= len_x;
    take      = active && full_now && (!best_valid || (sum_new > best));

    res_bv      = best_valid || take;
    res_sum     = take ? sum_new : best;
    res_idx     = take ? IDX_W'(start_x) : best_index;
    res_idx_ext = {{START_W{1'b0}}, res_idx};

    res.best_sum    = res_bv ? res_sum[SUM_W-1:0] : '0;
    res.best_start  = res_bv ? res_idx_ext[START_W-1:0] : '0;
    res.window_full = res_bv;
    res.set_done    = in_data.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      best        <= '0;
      best_index  <= '0;
      best_valid  <= 1'b0;
      count       <= '0;
    end else if (accept) begin
      if (in_data.last) begin
        running_sum <= '0;
        best        <= '0;
        best_index  <= '0;
        best_valid  <= 1'b0;
        count       <= '0;
      end else if (active) begin
        running_sum <= sum_new;
        count       <= CNT_W'(cnt_new_x);
        if (take) begin
          best       <= sum_new;
          best_index <= IDX_W'(start_x);
          best_valid <= 1'b1;
        end
      end
    end
  end

  // two-entry output buffer; skid only fills while the head is stalled
  assign in_ready = !skid_valid;
  assign pop      = out_valid && out_ready;

  always_comb begin
    out_valid_next  = out_valid;
    skid_valid_next = skid_valid;
    if (accept) begin
      if (out_valid && !pop) begin
        skid_valid_next = 1'b1;
      end else begin
        out_valid_next = 1'b1;
      end
    end else if (pop) begin
      out_valid_next  = skid_valid;
      skid_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (out_valid && !pop) begin
        skid <= res;
      end else begin
        out_data <= res;
      end
    end else if (pop && skid_valid) begin
      out_data <= skid;
    end
  end

  // checks
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && accept) |=> skid_valid)
    else $error("request taken during stall was not buffered");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("sample count past limit");

  a_empty_best: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.window_full) |->
      (out_data.best_sum == '0 && out_data.best_start == '0))
    else $error("result fields set before a full window");

endmodule
